[src/md5_stream_hasher_defines.svh]
// assertion macros for the md5 stream hasher
// used by the top level only, expects clk and arst_n in scope
`ifndef MD5_STREAM_HASHER_DEFINES_SVH
`define MD5_STREAM_HASHER_DEFINES_SVH

// same-cycle implication
`define MD5_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MD5_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/md5_pkg.sv]
// md5 stream hasher package: opcodes, states, command and status types, round tables
// no dependencies
`timescale 1ns / 1ps

package md5_pkg;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_FINAL  = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE,
		ST_ROUND,
		ST_FINISH,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		MODE_BLOCK,
		MODE_FIN1,
		MODE_FIN2
	} mode_t;

	typedef struct packed {
		logic       append;
		logic       clear;
		logic       load;
		logic       round_en;
		logic [5:0] rnd;
		logic [5:0] rd_rnd;
		logic       finish;
		mode_t      mode;
		logic [1:0] emit_idx;
	} cmd_t;

	typedef struct packed {
		logic fill_last;
		logic pad_two;
	} status_t;

	localparam logic [31:0] INIT_H0 = 32'h67452301;
	localparam logic [31:0] INIT_H1 = 32'hefcdab89;
	localparam logic [31:0] INIT_H2 = 32'h98badcfe;
	localparam logic [31:0] INIT_H3 = 32'h10325476;
	localparam logic [31:0] PAD_BYTE = 32'h00000080;
	localparam logic [5:0]  FILL_LAST = 6'd63;
	localparam logic [5:0]  PAD_LIMIT = 6'd55;
	localparam logic [5:0]  ROUND_LAST = 6'd63;
	localparam logic [3:0]  LEN_WORD_LO = 4'd14;
	localparam logic [3:0]  LEN_WORD_HI = 4'd15;
	localparam logic [1:0]  WORD_LAST = 2'd3;

	function automatic logic [31:0] round_const(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0:  k = 32'hd76aa478;
			6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;
			6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;
			6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;
			6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;
			6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;
			6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;
			6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;
			6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;
			6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;
			6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;
			6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;
			6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;
			6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;
			6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;
			6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;
			6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;
			6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;
			6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;
			6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;
			6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;
			6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;
			6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;
			6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;
			default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] rot_amount(input logic [5:0] r);
		logic [4:0] s;
		case ({r[5:4], r[1:0]})
			4'd0:  s = 5'd7;
			4'd1:  s = 5'd12;
			4'd2:  s = 5'd17;
			4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;
			4'd5:  s = 5'd9;
			4'd6:  s = 5'd14;
			4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;
			4'd9:  s = 5'd11;
			4'd10: s = 5'd16;
			4'd11: s = 5'd23;
			4'd12: s = 5'd6;
			4'd13: s = 5'd10;
			4'd14: s = 5'd15;
			default: s = 5'd21;
		endcase
		return s;
	endfunction

	function automatic logic [3:0] msg_idx(input logic [5:0] r);
		logic [3:0] r4;
		logic [3:0] g;
		r4 = r[3:0];
		case (r[5:4])
			2'd0:    g = r4;
			2'd1:    g = 4'((r4 << 2) + r4 + 4'd1);
			2'd2:    g = 4'((r4 << 1) + r4 + 4'd5);
			default: g = 4'((r4 << 3) - r4);
		endcase
		return g;
	endfunction

	function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		case (grp)
			2'd0:    f = (b & c) | (~b & d);
			2'd1:    f = (d & b) | (~d & c);
			2'd2:    f = b ^ c ^ d;
			default: f = c ^ (b | ~d);
		endcase
		return f;
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
		logic [63:0] dbl;
		dbl = {v, v} << n;
		return dbl[63:32];
	endfunction

endpackage

[src/md5_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module md5_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/md5_ctrl.sv]
// md5 stream hasher controller: handshakes, round counter, block and finalize sequencing
// depends on md5_pkg
`timescale 1ns / 1ps

module md5_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [1:0]       opcode,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  md5_pkg::status_t status,
	output md5_pkg::cmd_t    cmd
);

	md5_pkg::state_t state_q, state_d;
	md5_pkg::mode_t  mode_q, mode_d;
	logic [5:0]      rnd_q, rnd_d;
	logic [1:0]      emit_q, emit_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= md5_pkg::ST_IDLE;
			mode_q  <= md5_pkg::MODE_BLOCK;
			rnd_q   <= '0;
			emit_q  <= '0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			rnd_q   <= rnd_d;
			emit_q  <= emit_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		mode_d       = mode_q;
		rnd_d        = rnd_q;
		emit_d       = emit_q;
		s_tready     = 1'b0;
		m_tvalid     = 1'b0;
		cmd          = '0;
		cmd.mode     = mode_q;
		cmd.rnd      = rnd_q;
		cmd.rd_rnd   = 6'(rnd_q + 6'd1);
		cmd.emit_idx = emit_q;
		unique case (state_q)
			md5_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					unique case (md5_pkg::op_t'(opcode))
						md5_pkg::OP_APPEND: begin
							cmd.append = 1'b1;
							if (status.fill_last) begin
								mode_d  = md5_pkg::MODE_BLOCK;
								state_d = md5_pkg::ST_PRE;
							end
						end
						md5_pkg::OP_FINAL: begin
							mode_d  = md5_pkg::MODE_FIN1;
							state_d = md5_pkg::ST_PRE;
						end
						md5_pkg::OP_CLEAR: begin
							cmd.clear = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			md5_pkg::ST_PRE: begin
				cmd.load   = 1'b1;
				cmd.rd_rnd = '0;
				rnd_d      = '0;
				state_d    = md5_pkg::ST_ROUND;
			end
			md5_pkg::ST_ROUND: begin
				cmd.round_en = 1'b1;
				rnd_d        = 6'(rnd_q + 6'd1);
				if (rnd_q == md5_pkg::ROUND_LAST) begin
					state_d = md5_pkg::ST_FINISH;
				end
			end
			md5_pkg::ST_FINISH: begin
				cmd.finish = 1'b1;
				case (mode_q)
					md5_pkg::MODE_BLOCK: state_d = md5_pkg::ST_IDLE;
					md5_pkg::MODE_FIN1: begin
						if (status.pad_two) begin
							mode_d  = md5_pkg::MODE_FIN2;
							state_d = md5_pkg::ST_PRE;
						end else begin
							state_d = md5_pkg::ST_EMIT;
						end
					end
					default: state_d = md5_pkg::ST_EMIT;
				endcase
			end
			md5_pkg::ST_EMIT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					if (emit_q == md5_pkg::WORD_LAST) begin
						emit_d  = '0;
						state_d = md5_pkg::ST_IDLE;
					end else begin
						emit_d = 2'(emit_q + 2'd1);
					end
				end
			end
			default: state_d = md5_pkg::ST_IDLE;
		endcase
	end

endmodule

[src/md5_dpath.sv]
// md5 stream hasher datapath: block buffer, fill and length counters, round unit, chain words
// depends on md5_pkg and md5_ram
`timescale 1ns / 1ps

module md5_dpath (
	input  logic             clk,
	input  logic             arst_n,
	input  md5_pkg::cmd_t    cmd,
	input  logic [7:0]       data_byte,
	output md5_pkg::status_t status,
	output logic [31:0]      digest_word
);

	logic [5:0]  fill_q;
	logic [63:0] len_q;
	logic [23:0] part_q;
	logic [31:0] chain_q [4];
	logic [31:0] work_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [3:0]  msg_idx_s1;

	logic        ram_we;
	logic [3:0]  ram_raddr;
	logic [31:0] ram_wdata;
	logic [31:0] ram_rdata;
	logic [31:0] pad_word;
	logic [31:0] msg;
	logic        add_len;
	logic [31:0] src [4];
	logic [31:0] sum_t;
	logic [31:0] new_b;

	assign ram_we    = cmd.append && (fill_q[1:0] == 2'd3);
	assign ram_wdata = {data_byte, part_q};
	assign ram_raddr = md5_pkg::msg_idx(cmd.rd_rnd);

	md5_ram #(
		.WIDTH(32),
		.DEPTH(16)
	) u_buf (
		.clk  (clk),
		.we   (ram_we),
		.waddr(fill_q[5:2]),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign status.fill_last = (fill_q == md5_pkg::FILL_LAST);
	assign status.pad_two   = (fill_q > md5_pkg::PAD_LIMIT);

	// pending bytes of the partial word, then the 0x80 marker
	always_comb begin
		case (fill_q[1:0])
			2'd0:    pad_word = md5_pkg::PAD_BYTE;
			2'd1:    pad_word = {16'h0000, md5_pkg::PAD_BYTE[7:0], part_q[7:0]};
			2'd2:    pad_word = {8'h00, md5_pkg::PAD_BYTE[7:0], part_q[15:0]};
			default: pad_word = {md5_pkg::PAD_BYTE[7:0], part_q};
		endcase
	end

	assign add_len = ((cmd.mode == md5_pkg::MODE_FIN1) && !status.pad_two) ||
		(cmd.mode == md5_pkg::MODE_FIN2);

	always_comb begin
		msg = '0;
		case (cmd.mode)
			md5_pkg::MODE_BLOCK: msg = ram_rdata;
			md5_pkg::MODE_FIN1: begin
				if (msg_idx_s1 < fill_q[5:2]) begin
					msg = ram_rdata;
				end else if (msg_idx_s1 == fill_q[5:2]) begin
					msg = pad_word;
				end
			end
			default: msg = '0;
		endcase
		if (add_len && (msg_idx_s1 == md5_pkg::LEN_WORD_LO)) begin
			msg = len_q[31:0];
		end else if (add_len && (msg_idx_s1 == md5_pkg::LEN_WORD_HI)) begin
			msg = len_q[63:32];
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			src[i] = (cmd.mode == md5_pkg::MODE_FIN2) ? work_q[i] : chain_q[i];
		end
	end

	assign sum_t = a_q + md5_pkg::round_f(cmd.rnd[5:4], b_q, c_q, d_q) + msg +
		md5_pkg::round_const(cmd.rnd);
	assign new_b = md5_pkg::rotl(sum_t, md5_pkg::rot_amount(cmd.rnd)) + b_q;

	assign digest_word = work_q[cmd.emit_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			len_q      <= '0;
			chain_q[0] <= md5_pkg::INIT_H0;
			chain_q[1] <= md5_pkg::INIT_H1;
			chain_q[2] <= md5_pkg::INIT_H2;
			chain_q[3] <= md5_pkg::INIT_H3;
			for (int i = 0; i < 4; i++) begin
				work_q[i] <= '0;
			end
		end else begin
			if (cmd.append) begin
				fill_q <= 6'(fill_q + 6'd1);
				len_q  <= 64'(len_q + 64'd8);
			end
			if (cmd.clear) begin
				fill_q     <= '0;
				len_q      <= '0;
				chain_q[0] <= md5_pkg::INIT_H0;
				chain_q[1] <= md5_pkg::INIT_H1;
				chain_q[2] <= md5_pkg::INIT_H2;
				chain_q[3] <= md5_pkg::INIT_H3;
				for (int i = 0; i < 4; i++) begin
					work_q[i] <= '0;
				end
			end
			if (cmd.finish) begin
				if (cmd.mode == md5_pkg::MODE_BLOCK) begin
					chain_q[0] <= src[0] + a_q;
					chain_q[1] <= src[1] + b_q;
					chain_q[2] <= src[2] + c_q;
					chain_q[3] <= src[3] + d_q;
				end else begin
					work_q[0] <= src[0] + a_q;
					work_q[1] <= src[1] + b_q;
					work_q[2] <= src[2] + c_q;
					work_q[3] <= src[3] + d_q;
				end
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		msg_idx_s1 <= ram_raddr;
		if (cmd.append && (fill_q[1:0] != 2'd3)) begin
			part_q[{fill_q[1:0], 3'b000} +: 8] <= data_byte;
		end
		if (cmd.load) begin
			a_q <= src[0];
			b_q <= src[1];
			c_q <= src[2];
			d_q <= src[3];
		end else if (cmd.round_en) begin
			a_q <= d_q;
			b_q <= new_b;
			c_q <= b_q;
			d_q <= c_q;
		end
	end

endmodule

[src/md5_stream_hasher.sv]
// md5 stream hasher top level: byte-serial md5 with streaming input and digest output
// depends on md5_pkg, md5_ctrl, md5_dpath, md5_ram and md5_stream_hasher_defines.svh
//
// channel  direction  signals                     contents
// s_*      in         tvalid tready tdata tuser   tdata: data_byte; tuser: opcode
// m_*      out        tvalid tready tdata tlast   tdata: digest_word, word_index; tlast: last_word
//
// append and clear words are taken in the idle state
// the byte that completes a block holds s_tready low through load, 64 rounds and add
// finalize runs one compression, or two with more than 55 bytes pending, then four output words
// asynchronous reset loads the md5 initial chain; no clearing pass is needed
// s_tready stays low while digest words wait; a stalled output word holds
`timescale 1ns / 1ps
`include "md5_stream_hasher_defines.svh"

module md5_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic [1:0]  s_tuser,  // [1:0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [31:0] digest_word, [33:32] word_index, zero above
	output logic        m_tlast   // last_word
);

	md5_pkg::cmd_t    cmd;
	md5_pkg::status_t status;
	logic [31:0]      digest_word;

	md5_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.opcode  (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.status  (status),
		.cmd     (cmd)
	);

	md5_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.data_byte  (s_tdata),
		.status     (status),
		.digest_word(digest_word)
	);

	assign m_tdata = {6'b000000, cmd.emit_idx, digest_word};
	assign m_tlast = (cmd.emit_idx == md5_pkg::WORD_LAST);

	`MD5_ASSERT_NOW(a_no_overlap, 1'b1, !(s_tready && m_tvalid), "input taken during output")
	`MD5_ASSERT_NEXT(a_word_follows, m_tvalid && m_tready && !m_tlast, m_tvalid, "digest cut short")
	`MD5_ASSERT_NEXT(a_back_idle, m_tvalid && m_tready && m_tlast, s_tready, "no return to idle")
	`MD5_ASSERT_NEXT(a_final_busy, s_tvalid && s_tready && (s_tuser == md5_pkg::OP_FINAL), !s_tready && !m_tvalid, "finalize did not start compression")

endmodule

[dv/md5_digest_checker.sv]
// md5 digest checker: watches both stream channels, predicts digest words, compares them
// depends on md5_pkg for opcodes and the initial chain values
`timescale 1ns / 1ps

module md5_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic [1:0]  s_tuser,  // [1:0] opcode
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,  // [31:0] digest_word, [33:32] word_index
	input  logic        m_tlast,  // last_word
	output int          fail_count,
	output int          words_due,
	output int          words_checked
);

	localparam logic [0:63][31:0] SINE_K = {
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [0:15][4:0] ROT_S = {
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	localparam logic [127:0] CHAIN_INIT = {md5_pkg::INIT_H3, md5_pkg::INIT_H2,
		md5_pkg::INIT_H1, md5_pkg::INIT_H0};

	typedef struct packed {
		logic [31:0] word;
		logic [1:0]  idx;
		logic        last;
	} digest_word_t;

	digest_word_t   due_q[$];
	logic [511:0]   msg_bytes;  // byte i at [8i+7:8i]
	int unsigned    fill;
	logic [63:0]    msg_bits;
	logic [127:0]   chain;      // h0 in the low word

	// one 64-round compression; block words are little-endian by placement
	function automatic logic [127:0] md5_block(input logic [127:0] h, input logic [511:0] blk);
		logic [31:0] a, b, c, d, f, t;
		int g;
		int s;
		a = h[31:0];
		b = h[63:32];
		c = h[95:64];
		d = h[127:96];
		for (int r = 0; r < 64; r++) begin
			case (r / 16)
				0: begin
					f = (b & c) | (~b & d);
					g = r;
				end
				1: begin
					f = (d & b) | (~d & c);
					g = (5 * r + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * r + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * r) % 16;
				end
			endcase
			t = a + f + blk[32 * g +: 32] + SINE_K[r];
			s = ROT_S[(r / 16) * 4 + r % 4];
			t = ((t << s) | (t >> (32 - s))) + b;
			a = d;
			d = c;
			c = b;
			b = t;
		end
		return {h[127:96] + d, h[95:64] + c, h[63:32] + b, h[31:0] + a};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		digest_word_t want;
		logic [511:0] pad;
		logic [127:0] fin;
		if (!arst_n) begin
			due_q.delete();
			msg_bytes = '0;
			fill = 0;
			msg_bits = '0;
			chain = CHAIN_INIT;
			fail_count = 0;
			words_checked = 0;
			words_due <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_q.size() == 0) begin
					$error("digest word %h with nothing expected", m_tdata[31:0]);
					fail_count = fail_count + 1;
				end else begin
					want = due_q.pop_front();
					words_checked = words_checked + 1;
					if (m_tdata[31:0] !== want.word) begin
						$error("digest_word: expected %h, got %h", want.word, m_tdata[31:0]);
						fail_count = fail_count + 1;
					end
					if (m_tdata[33:32] !== want.idx) begin
						$error("word_index: expected %0d, got %0d", want.idx, m_tdata[33:32]);
						fail_count = fail_count + 1;
					end
					if (m_tlast !== want.last) begin
						$error("last_word: expected %0d, got %0d", want.last, m_tlast);
						fail_count = fail_count + 1;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					md5_pkg::OP_APPEND: begin
						msg_bytes[8 * fill +: 8] = s_tdata;
						msg_bits = msg_bits + 64'd8;
						if (fill == 63) begin
							chain = md5_block(chain, msg_bytes);
							fill = 0;
						end else begin
							fill = fill + 1;
						end
					end
					md5_pkg::OP_CLEAR: begin
						fill = 0;
						msg_bits = '0;
						chain = CHAIN_INIT;
					end
					md5_pkg::OP_FINAL: begin
						pad = msg_bytes;
						pad[8 * fill +: 8] = 8'h80;
						for (int i = fill + 1; i < 64; i++)
							pad[8 * i +: 8] = 8'h00;
						fin = chain;
						// no room for the length: spill into a second block
						if (fill > 55) begin
							fin = md5_block(fin, pad);
							pad = '0;
						end
						pad[511:448] = msg_bits;
						fin = md5_block(fin, pad);
						for (int i = 0; i < 4; i++) begin
							want.word = fin[32 * i +: 32];
							want.idx = 2'(i);
							want.last = (i == 3);
							due_q.push_back(want);
						end
					end
					default: ;
				endcase
			end
			words_due <= due_q.size();
		end
	end

endmodule

[dv/tb_top.sv]
// testbench top for the md5 stream hasher: clock, reset, stimulus and verdict
// depends on md5_pkg, md5_stream_hasher and md5_digest_checker
`timescale 1ns / 1ps

module tb_top;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 215;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tready = 1'b0;
	logic        s_tready;
	logic        m_tvalid;
	logic [39:0] m_tdata;
	logic        m_tlast;

	int fail_count;
	int words_due;
	int words_checked;
	int idle_pct = 0;
	int stall_pct = 0;
	int sent = 0;
	int fill_pos = 0;
	int n_append = 0;
	int n_final = 0;
	int n_clear = 0;
	int n_unused = 0;

	md5_stream_hasher dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	md5_digest_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.fail_count    (fail_count),
		.words_due     (words_due),
		.words_checked (words_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic push_word(input logic [1:0] op, input logic [7:0] b);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		case (op)
			md5_pkg::OP_APPEND: begin
				n_append++;
				fill_pos = (fill_pos + 1) % 64;
			end
			md5_pkg::OP_FINAL: n_final++;
			md5_pkg::OP_CLEAR: begin
				n_clear++;
				fill_pos = 0;
			end
			default: n_unused++;
		endcase
		if (op != OP_UNUSED)
			sent++;
	endtask

	// hold the sender off until every digest word has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (words_due != 0);
	endtask

	initial begin
		int base;
		int ph;
		int cur_ph;
		int len;
		int tgt;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message, short messages, repeated finalize, ignored opcode, clear
		push_word(md5_pkg::OP_FINAL, 8'hff);
		push_word(md5_pkg::OP_APPEND, 8'h00);
		push_word(md5_pkg::OP_APPEND, 8'hff);
		push_word(md5_pkg::OP_FINAL, 8'ha5);
		push_word(md5_pkg::OP_FINAL, 8'h00);
		push_word(OP_UNUSED, 8'h5a);
		push_word(md5_pkg::OP_FINAL, 8'h3c);
		push_word(md5_pkg::OP_CLEAR, 8'hff);
		push_word(md5_pkg::OP_APPEND, 8'h61);
		push_word(md5_pkg::OP_APPEND, 8'h62);
		push_word(md5_pkg::OP_APPEND, 8'h63);
		push_word(md5_pkg::OP_FINAL, 8'h00);
		push_word(md5_pkg::OP_APPEND, 8'h80);
		push_word(md5_pkg::OP_CLEAR, 8'h00);
		push_word(md5_pkg::OP_APPEND, 8'h7f);
		push_word(md5_pkg::OP_FINAL, 8'hc3);
		wait_drained();

		base = sent;
		cur_ph = 0;
		while (sent < base + RANDOM_ITEMS) begin
			ph = (sent - base) * 4 / RANDOM_ITEMS;
			if (ph > 3)
				ph = 3;
			if (ph != cur_ph) begin
				cur_ph = ph;
				wait_drained();
				case (ph)
					1: begin
						idle_pct = 54;
						stall_pct = 0;
					end
					2: begin
						idle_pct = 0;
						stall_pct = 54;
					end
					default: begin
						idle_pct = 9;
						stall_pct = 9;
					end
				endcase
			end
			case ($urandom_range(0, 19))
				0: push_word(md5_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
				1: push_word(OP_UNUSED, 8'($urandom_range(0, 255)));
				default: begin
					if ($urandom_range(0, 2) == 0) begin
						// land the pending count on a padding or block edge
						case ($urandom_range(0, 4))
							0: tgt = 55;
							1: tgt = 56;
							2: tgt = 57;
							3: tgt = 63;
							default: tgt = 64;
						endcase
						len = (tgt - fill_pos + 64) % 64;
					end else begin
						len = $urandom_range(0, 9);
					end
					repeat (len)
						push_word(md5_pkg::OP_APPEND, 8'($urandom_range(0, 255)));
					push_word(md5_pkg::OP_FINAL, 8'($urandom_range(0, 255)));
					if ($urandom_range(0, 5) == 0)
						push_word(md5_pkg::OP_FINAL, 8'($urandom_range(0, 255)));
				end
			endcase
		end

		wait_drained();
		repeat (140) @(posedge clk);
		$display("covered %0d appends, %0d finalizes, %0d clears, %0d unused-opcode words",
			n_append, n_final, n_clear, n_unused);
		$display("compared %0d digest words under four handshake pressure phases",
			words_checked);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
